### rtl/bes_pkg.sv
package bes_pkg;

   // table geometry
   localparam int MAX_POINTS = 64;
   localparam int ADDR_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);

   // field widths
   localparam int INDEX_W = 6;
   localparam int TIME_W  = 32;
   localparam int LEVEL_W = 24;
   localparam int COUNT_W = 7;

   // stream payload widths (whole bytes)
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 24;

   // multiply and divide
   localparam int PROD_W    = LEVEL_W + TIME_W;
   localparam int DIV_CNT_W = $clog2(LEVEL_W);

   // operation codes
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_SCAN_ADDR = 6'b000010,
      ST_SCAN_CMP  = 6'b000100,
      ST_MUL       = 6'b001000,
      ST_DIV       = 6'b010000,
      ST_DONE      = 6'b100000
   } state_type;

endpackage

### rtl/breakpoint_envelope_sampler.sv
// Write transaction: the entry is written to the table on acceptance; the block stays idle and ready.
// Sample transaction: per breakpoint visited, an address state and a compare state (one table read
// port), one more address state when the scan runs past the last point, a multiply state and 24
// restoring divide steps when interpolating, then a done state that loads the output register.
// One transaction at a time; a full output register stalls the load.
// Synchronous reset clears control and point_count; the table is undefined until written.
module breakpoint_envelope_sampler import bes_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // csr
   input  logic                  csr_we,
   input  logic [COUNT_W-1:0]    csr_wdata,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // entry_index[5:0], entry_time[37:6], entry_level[61:38], query_time[93:62]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // op[0]
   input  logic                  req_tuser,
   // response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // sampled_level[23:0]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // has_level[0]
   output logic                  rsp_tuser
);

   // unpack request
   logic [INDEX_W-1:0]        req_entry_index;
   logic [TIME_W-1:0]         req_entry_time;
   logic signed [LEVEL_W-1:0] req_entry_level;
   logic [TIME_W-1:0]         req_query_time;

   assign req_entry_index = req_tdata[5:0];
   assign req_entry_time  = req_tdata[37:6];
   assign req_entry_level = req_tdata[61:38];
   assign req_query_time  = req_tdata[93:62];

   // registers
   state_type                 state_ff, state_in;
   logic [COUNT_W-1:0]        point_count_ff;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          idx_ff, idx_in;
   logic [TIME_W-1:0]         query_ff, query_in;
   logic                      have_prev_ff, have_prev_in;
   logic [TIME_W-1:0]         prev_time_ff, prev_time_in;
   logic signed [LEVEL_W-1:0] prev_level_ff, prev_level_in;
   logic [TIME_W-1:0]         num_ff, num_in;
   logic [TIME_W-1:0]         den_ff, den_in;
   logic [LEVEL_W-1:0]        mag_ff, mag_in;
   logic                      neg_ff, neg_in;
   logic [TIME_W-1:0]         rem_ff, rem_in;
   logic [LEVEL_W-1:0]        dvd_ff, dvd_in;
   logic [LEVEL_W-1:0]        quot_ff, quot_in;
   logic [DIV_CNT_W-1:0]      bit_ff, bit_in;
   logic                      res_has_ff, res_has_in;
   logic signed [LEVEL_W-1:0] res_level_ff, res_level_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_has_ff, rsp_has_in;
   logic [LEVEL_W-1:0]        rsp_level_ff, rsp_level_in;

   // table
   logic [TIME_W-1:0]         time_mem [MAX_POINTS];
   logic signed [LEVEL_W-1:0] level_mem [MAX_POINTS];
   logic [TIME_W-1:0]         rd_time_ff;
   logic signed [LEVEL_W-1:0] rd_level_ff;

   logic                      req_accept;
   logic                      mem_we;
   logic [ADDR_W-1:0]         wr_addr;
   logic [ADDR_W-1:0]         rd_addr;
   logic [CNT_W-1:0]          count_clamped;
   logic signed [LEVEL_W:0]   diff;
   logic [PROD_W-1:0]         prod;
   logic [TIME_W:0]           trial;
   logic                      out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign mem_we     = req_accept && (req_tuser == OP_WRITE)
                       && (32'(req_entry_index) < MAX_POINTS);
   assign wr_addr    = ADDR_W'(req_entry_index);
   assign rd_addr    = idx_ff[ADDR_W-1:0];

   assign count_clamped = (32'(point_count_ff) > MAX_POINTS) ? CNT_W'(MAX_POINTS)
                                                               : CNT_W'(point_count_ff);

   // shared arithmetic
   assign diff  = {rd_level_ff[LEVEL_W-1], rd_level_ff}
                  - {prev_level_ff[LEVEL_W-1], prev_level_ff};
   assign prod  = PROD_W'(mag_ff) * PROD_W'(num_ff);
   assign trial = {rem_ff, dvd_ff[LEVEL_W-1]} - {1'b0, den_ff};

   assign out_free = !rsp_valid_ff || rsp_tready;

   // write and read the table
   always_ff @(posedge clock) begin
      if (mem_we) begin
         time_mem[wr_addr]  <= req_entry_time;
         level_mem[wr_addr] <= req_entry_level;
      end
      rd_time_ff  <= time_mem[rd_addr];
      rd_level_ff <= level_mem[rd_addr];
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      query_in      = query_ff;
      have_prev_in  = have_prev_ff;
      prev_time_in  = prev_time_ff;
      prev_level_in = prev_level_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      rem_in        = rem_ff;
      dvd_in        = dvd_ff;
      quot_in       = quot_ff;
      bit_in        = bit_ff;
      res_has_in    = res_has_ff;
      res_level_in  = res_level_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_has_in    = rsp_has_ff;
      rsp_level_in  = rsp_level_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_tuser == OP_SAMPLE)) begin
               count_in     = count_clamped;
               query_in     = req_query_time;
               idx_in       = '0;
               have_prev_in = 1'b0;
               if (count_clamped == '0) begin
                  res_has_in   = 1'b0;
                  res_level_in = '0;
                  state_in     = ST_DONE;
               end else begin
                  res_has_in = 1'b1;
                  state_in   = ST_SCAN_ADDR;
               end
            end
         end
         ST_SCAN_ADDR: begin
            // past the last point: hold the last level
            if (idx_ff == count_ff) begin
               res_level_in = prev_level_ff;
               state_in     = ST_DONE;
            end else begin
               state_in = ST_SCAN_CMP;
            end
         end
         ST_SCAN_CMP: begin
            if (rd_time_ff <= query_ff) begin
               have_prev_in  = 1'b1;
               prev_time_in  = rd_time_ff;
               prev_level_in = rd_level_ff;
               idx_in        = idx_ff + 1'b1;
               state_in      = ST_SCAN_ADDR;
            end else if (!have_prev_ff) begin
               // before the first point: give the first level
               res_level_in = rd_level_ff;
               state_in     = ST_DONE;
            end else begin
               num_in   = query_ff - prev_time_ff;
               den_in   = rd_time_ff - prev_time_ff;
               neg_in   = diff[LEVEL_W];
               mag_in   = diff[LEVEL_W] ? LEVEL_W'(-diff) : LEVEL_W'(diff);
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // product high part is below the divisor, quotient fits the level width
            rem_in   = prod[PROD_W-1:LEVEL_W];
            dvd_in   = prod[LEVEL_W-1:0];
            quot_in  = '0;
            bit_in   = DIV_CNT_W'(LEVEL_W - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // one restoring step per cycle
            if (!trial[TIME_W]) begin
               rem_in  = trial[TIME_W-1:0];
               quot_in = {quot_ff[LEVEL_W-2:0], 1'b1};
            end else begin
               rem_in  = {rem_ff[TIME_W-2:0], dvd_ff[LEVEL_W-1]};
               quot_in = {quot_ff[LEVEL_W-2:0], 1'b0};
            end
            dvd_in = {dvd_ff[LEVEL_W-2:0], 1'b0};
            bit_in = bit_ff - 1'b1;
            if (bit_ff == '0) begin
               res_level_in = neg_ff ? (prev_level_ff - $signed(quot_in))
                                     : (prev_level_ff + $signed(quot_in));
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            // hand over once the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_has_in   = res_has_ff;
               rsp_level_in = res_level_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         point_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            point_count_ff <= csr_wdata;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      count_ff      <= count_in;
      idx_ff        <= idx_in;
      query_ff      <= query_in;
      have_prev_ff  <= have_prev_in;
      prev_time_ff  <= prev_time_in;
      prev_level_ff <= prev_level_in;
      num_ff        <= num_in;
      den_ff        <= den_in;
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      rem_ff        <= rem_in;
      dvd_ff        <= dvd_in;
      quot_ff       <= quot_in;
      bit_ff        <= bit_in;
      res_has_ff    <= res_has_in;
      res_level_ff  <= res_level_in;
      rsp_has_ff    <= rsp_has_in;
      rsp_level_ff  <= rsp_level_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_level_ff;
   assign rsp_tuser  = rsp_has_ff;

endmodule
